>>> rtl/block_pool_allocator_core_defines.svh
// Assertion macros used by the checker file of the pool allocator.
`ifndef BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, clocked on aclk and disabled while aresetn is low.
`define BPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pool allocator check failed");

// Next-cycle implication, clocked on aclk and disabled while aresetn is low.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pool allocator check failed");

`endif

>>> rtl/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

    // Request kinds carried on s_tuser.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK            = 2'd0;
    localparam logic [1:0] STATUS_OUT_OF_BLOCKS = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ITEM_SIZE       = 2'd0;
    localparam logic [1:0] CFG_ITEMS_PER_BLOCK = 2'd1;

    localparam int ADDR_W   = 16;
    localparam int SIZE_W   = 13;
    localparam int IPB_W    = 11;
    localparam int SPAN_W   = SIZE_W + IPB_W;
    localparam int TDATA_W  = 24;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EXEC,
        S_FETCH
    } state_t;

endpackage

>>> rtl/block_pool_allocator_core.sv
`timescale 1ns / 1ps
// Sequence: a request is accepted in S_IDLE and then steps through S_CALC, S_EXEC and S_FETCH;
// the result is loaded into the output register in S_FETCH once the result side is not stalled.
// New requests are taken only after the last result has been loaded, for allocate, free and clear
// alike, set by the calculate / update / fetch sequence around at most one offset memory access.
// Reset (aresetn low, synchronous) empties all blocks and the handshakes; the offset memory is
// not cleared, since no entry is read before it has been written.

module block_pool_allocator_core #(
    parameter int MAX_BLOCKS  = 8,
    parameter int BLOCK_BYTES = 8192,
    parameter int MAX_ITEMS   = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    // Request channel.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bpa_pkg::ADDR_W-1:0]  s_tdata,   // [15:0] address
    input  logic [1:0]                  s_tuser,   // [1:0] mode

    // Result channel.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bpa_pkg::TDATA_W-1:0] m_tdata,   // [15:0] result_address, [17:16] status,
                                                   // [23:18] zero

    // Configuration write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [bpa_pkg::SIZE_W-1:0]  cfg_data
);

    import bpa_pkg::*;

    // Block size is a power of two: the block number is the upper address bits and the slot
    // offset the lower OFF_W bits.
    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int BLK_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int ACT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DEPTH   = MAX_BLOCKS * MAX_ITEMS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Control state.
    state_t             state_reg, state_next;
    logic [ACT_W-1:0]   active_reg, active_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Configuration registers.
    logic [SIZE_W-1:0]  size_reg;
    logic [IPB_W-1:0]   ipb_reg;

    // Per-block stack state. Each stack holds its initial fill pattern below its fill level:
    // those entries are computed from the stored fill count and item size, and only entries at
    // or above the level live in the offset memory. A push below the level lowers it.
    logic [CNT_W-1:0]   top_reg  [MAX_BLOCKS];
    logic [CNT_W-1:0]   top_next [MAX_BLOCKS];
    logic [CNT_W-1:0]   lvl_reg  [MAX_BLOCKS];
    logic [CNT_W-1:0]   lvl_next [MAX_BLOCKS];
    logic [CNT_W-1:0]   fn_reg   [MAX_BLOCKS];
    logic [CNT_W-1:0]   fn_next  [MAX_BLOCKS];
    logic [SIZE_W-1:0]  fs_reg   [MAX_BLOCKS];
    logic [SIZE_W-1:0]  fs_next  [MAX_BLOCKS];

    // Captured request and per-request working registers.
    logic [1:0]         mode_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [SPAN_W-1:0]  span_reg, span_next;
    logic [CNT_W-1:0]   diff_reg, diff_next;
    logic [SIZE_W-1:0]  mul_size_reg, mul_size_next;
    logic               use_mem_reg, use_mem_next;
    logic [BLK_W-1:0]   res_blk_reg, res_blk_next;
    logic               res_ok_reg, res_ok_next;
    logic [1:0]         status_reg, status_next;

    // Output register.
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [1:0]         out_status_reg, out_status_next;

    // Sequencer strobes.
    logic               calc_en, exec_en, fin_en, out_free;

    // Offset memory port signals.
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [OFF_W-1:0]   ram_wdata, ram_rdata;

    // Search and decode results.
    logic               found;
    logic [BLK_W-1:0]   sel;
    logic [CNT_W-1:0]   pop_idx;
    logic [16:0]        fblk_wide;
    logic [BLK_W-1:0]   fblk;
    logic [OFF_W-1:0]   foff;
    logic               f_hit;
    logic [CNT_W-1:0]   f_top;
    logic [BLK_W-1:0]   nb;
    logic [31:0]        mul_prod;
    logic [OFF_W-1:0]   fetch_off;

    // Both input channels stay closed while reset is held, so no transfer is taken and lost.
    assign cfg_ready = aresetn;
    assign s_tready  = aresetn && (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(TDATA_W - ADDR_W - 2){1'b0}}, out_status_reg, out_addr_reg};
    assign out_free  = !m_tvalid_reg || m_tready;

    bpa_ram #(
        .WIDTH (OFF_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_offsets (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_FETCH;
            end
            S_FETCH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer: strobes.
    always_comb begin
        calc_en = 1'b0;
        exec_en = 1'b0;
        fin_en  = 1'b0;
        case (state_reg)
            S_CALC: begin
                calc_en = 1'b1;
            end
            S_EXEC: begin
                exec_en = 1'b1;
            end
            S_FETCH: begin
                fin_en = out_free;
            end
            default: begin
                calc_en = 1'b0;
            end
        endcase
    end

    // Newest active block with a non-empty stack wins.
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            if ((ACT_W'(k) < active_reg) && (top_reg[k] != '0)) begin
                found = 1'b1;
                sel   = BLK_W'(k);
            end
        end
    end

    assign pop_idx   = top_reg[sel] - CNT_W'(1);

    // Free decode: the block must be active and the offset inside the slot span. Since the
    // offset is always below the block size, comparing against the raw product is enough.
    assign fblk_wide = 17'(addr_reg >> OFF_W);
    assign fblk      = fblk_wide[BLK_W-1:0];
    assign foff      = addr_reg[OFF_W-1:0];
    assign f_hit     = (fblk_wide < 17'(active_reg)) && (SPAN_W'(foff) < span_reg);
    assign f_top     = top_reg[fblk];
    assign nb        = active_reg[BLK_W-1:0];

    // Offset of a slot in its initial fill pattern, modulo the block size.
    assign mul_prod  = 32'(diff_reg) * 32'(mul_size_reg);
    assign fetch_off = use_mem_reg ? ram_rdata : mul_prod[OFF_W-1:0];

    always_comb begin
        active_next     = active_reg;
        m_tvalid_next   = m_tvalid_reg;
        n_next          = n_reg;
        span_next       = span_reg;
        diff_next       = diff_reg;
        mul_size_next   = mul_size_reg;
        use_mem_next    = use_mem_reg;
        res_blk_next    = res_blk_reg;
        res_ok_next     = res_ok_reg;
        status_next     = status_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        top_next        = top_reg;
        lvl_next        = lvl_reg;
        fn_next         = fn_reg;
        fs_next         = fs_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = '0;
        ram_raddr       = '0;
        ram_wdata       = foff;

        if (calc_en) begin
            n_next    = (32'(ipb_reg) < MAX_ITEMS) ? CNT_W'(ipb_reg) : CNT_W'(MAX_ITEMS);
            span_next = SPAN_W'(size_reg) * SPAN_W'(ipb_reg);
        end

        if (exec_en) begin
            res_ok_next = 1'b0;
            status_next = STATUS_OK;
            case (mode_reg)
                MODE_ALLOC: begin
                    if (found) begin
                        top_next[sel] = pop_idx;
                        use_mem_next  = !(pop_idx < lvl_reg[sel]);
                        diff_next     = fn_reg[sel] - CNT_W'(1) - pop_idx;
                        mul_size_next = fs_reg[sel];
                        ram_re        = !(pop_idx < lvl_reg[sel]);
                        ram_raddr     = AW'(32'(sel) * MAX_ITEMS + 32'(pop_idx));
                        res_blk_next  = sel;
                        res_ok_next   = 1'b1;
                    end else if ((active_reg >= ACT_W'(MAX_BLOCKS)) || (n_reg == '0)) begin
                        status_next = STATUS_OUT_OF_BLOCKS;
                    end else begin
                        // Activate the next block; its first pop is always offset zero.
                        fn_next[nb]   = n_reg;
                        fs_next[nb]   = size_reg;
                        top_next[nb]  = n_reg - CNT_W'(1);
                        lvl_next[nb]  = n_reg;
                        active_next   = active_reg + ACT_W'(1);
                        use_mem_next  = 1'b0;
                        diff_next     = '0;
                        mul_size_next = size_reg;
                        res_blk_next  = nb;
                        res_ok_next   = 1'b1;
                    end
                end
                MODE_FREE: begin
                    if (f_hit) begin
                        // A push onto a full stack is dropped, still with an ok status.
                        if (f_top < CNT_W'(MAX_ITEMS)) begin
                            ram_we         = 1'b1;
                            ram_waddr      = AW'(32'(fblk) * MAX_ITEMS + 32'(f_top[IDX_W-1:0]));
                            top_next[fblk] = f_top + CNT_W'(1);
                            if (f_top < lvl_reg[fblk]) begin
                                lvl_next[fblk] = f_top;
                            end
                        end
                    end else begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                MODE_CLEAR: begin
                    for (int k = 0; k < MAX_BLOCKS; k++) begin
                        if (ACT_W'(k) < active_reg) begin
                            fn_next[k]  = n_reg;
                            fs_next[k]  = size_reg;
                            top_next[k] = n_reg;
                            lvl_next[k] = n_reg;
                        end
                    end
                end
                default: begin
                    status_next = STATUS_OK;
                end
            endcase
        end

        if (fin_en) begin
            m_tvalid_next   = 1'b1;
            out_status_next = status_reg;
            out_addr_next   = res_ok_reg
                ? ADDR_W'((32'(res_blk_reg) << OFF_W) | 32'(fetch_off))
                : '0;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < MAX_BLOCKS; k++) begin
                top_reg[k] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            m_tvalid_reg <= m_tvalid_next;
            top_reg      <= top_next;
        end
    end

    // Configuration registers take their documented reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(8);
            ipb_reg  <= IPB_W'(1024);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ITEM_SIZE: begin
                    size_reg <= cfg_data;
                end
                CFG_ITEMS_PER_BLOCK: begin
                    ipb_reg <= cfg_data[IPB_W-1:0];
                end
                default: begin
                    size_reg <= size_reg;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tuser;
            addr_reg <= s_tdata;
        end
        lvl_reg        <= lvl_next;
        fn_reg         <= fn_next;
        fs_reg         <= fs_next;
        n_reg          <= n_next;
        span_reg       <= span_next;
        diff_reg       <= diff_next;
        mul_size_reg   <= mul_size_next;
        use_mem_reg    <= use_mem_next;
        res_blk_reg    <= res_blk_next;
        res_ok_reg     <= res_ok_next;
        status_reg     <= status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

endmodule

>>> rtl/bpa_ram.sv
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/bpa_checker.sv
`timescale 1ns / 1ps
`include "block_pool_allocator_core_defines.svh"

module bpa_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bpa_pkg::TDATA_W-1:0] m_tdata
);

    import bpa_pkg::*;

    // A stalled result holds its value.
    `BPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Requests are worked one at a time: the port closes after each transfer.
    `BPA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

    // A result never shows up in the cycle right after a request transfer.
    `BPA_ASSERT_NOW(a_no_early_result, $rose(m_tvalid), !$past(s_tvalid && s_tready))

    // Failed requests return a zero address, and the unused status code never appears.
    `BPA_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tdata[17:16] != STATUS_OK),
        (m_tdata[15:0] == '0) && (m_tdata[17:16] <= STATUS_NOT_FOUND))

endmodule

bind block_pool_allocator_core bpa_checker u_bpa_checker (.*);
